// File: rtl/ipbs_pkg.sv
// ----------------------------------------------------------------------------
// ipbs_pkg
// Types, constants and the microcode table for the square-and-multiply
// power unit.
// ----------------------------------------------------------------------------
package ipbs_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int EXP_W  = 8;
    localparam int PC_W   = 4;

    localparam logic [DATA_W-1:0] GUARD_BOUND = 64'd3037000499;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t ST_INIT    = 4'd0;
    localparam pc_t ST_CHECK   = 4'd1;
    localparam pc_t ST_SQ_LO   = 4'd2;
    localparam pc_t ST_SQ_HI   = 4'd3;
    localparam pc_t ST_MUL_LL  = 4'd4;
    localparam pc_t ST_MUL_LH  = 4'd5;
    localparam pc_t ST_MUL_HL  = 4'd6;
    localparam pc_t ST_SHIFT   = 4'd7;
    localparam pc_t ST_FINISH  = 4'd8;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_CHECK,
        OP_MAC,
        OP_SHIFT,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_TRIVIAL,
        COND_STOP,
        COND_REST_EVEN
    } cond_t;

    typedef enum logic [1:0] {
        A_BASE_LO,
        A_ACC_LO,
        A_ACC_HI
    } asel_t;

    typedef enum logic {
        B_BASE_LO,
        B_BASE_HI
    } bsel_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_33
    } shift_t;

    typedef enum logic [1:0] {
        DST_PROD,
        DST_BASE,
        DST_ACC
    } dst_t;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        pc_t    target;
        asel_t  a_sel;
        bsel_t  b_sel;
        shift_t shift;
        logic   add_prod;
        dst_t   dst;
    } ucode_t;

    function automatic ucode_t make_word(
        input op_t    op,
        input cond_t  cond,
        input pc_t    target,
        input asel_t  a_sel,
        input bsel_t  b_sel,
        input shift_t shift,
        input logic   add_prod,
        input dst_t   dst
    );
        ucode_t w;
        w.op       = op;
        w.cond     = cond;
        w.target   = target;
        w.a_sel    = a_sel;
        w.b_sel    = b_sel;
        w.shift    = shift;
        w.add_prod = add_prod;
        w.dst      = dst;
        return w;
    endfunction

    // Each squaring takes two multiplier passes and each accumulate three.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            ST_INIT:
            begin
                w = make_word(OP_INIT, COND_TRIVIAL, ST_FINISH,
                              A_BASE_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
            ST_CHECK:
            begin
                w = make_word(OP_CHECK, COND_STOP, ST_FINISH,
                              A_BASE_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
            ST_SQ_LO:
            begin
                w = make_word(OP_MAC, COND_NONE, ST_INIT,
                              A_BASE_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
            ST_SQ_HI:
            begin
                w = make_word(OP_MAC, COND_NONE, ST_INIT,
                              A_BASE_LO, B_BASE_HI, SH_33, 1'b1, DST_BASE);
            end
            ST_MUL_LL:
            begin
                w = make_word(OP_MAC, COND_REST_EVEN, ST_SHIFT,
                              A_ACC_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
            ST_MUL_LH:
            begin
                w = make_word(OP_MAC, COND_NONE, ST_INIT,
                              A_ACC_LO, B_BASE_HI, SH_32, 1'b1, DST_PROD);
            end
            ST_MUL_HL:
            begin
                w = make_word(OP_MAC, COND_NONE, ST_INIT,
                              A_ACC_HI, B_BASE_LO, SH_32, 1'b1, DST_ACC);
            end
            ST_SHIFT:
            begin
                w = make_word(OP_SHIFT, COND_ALWAYS, ST_CHECK,
                              A_BASE_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
            default:
            begin
                w = make_word(OP_DONE, COND_NONE, ST_FINISH,
                              A_BASE_LO, B_BASE_LO, SH_0, 1'b0, DST_PROD);
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ipbs_mac.sv
// ----------------------------------------------------------------------------
// ipbs_mac
// One 32 by 32 multiplier whose product is shifted into place and added to
// a 64-bit partial sum, modulo 2^64.
// ----------------------------------------------------------------------------
module ipbs_mac (
    input  logic [ipbs_pkg::HALF_W-1:0] a,
    input  logic [ipbs_pkg::HALF_W-1:0] b,
    input  logic [ipbs_pkg::DATA_W-1:0] addend,
    input  ipbs_pkg::shift_t            shift,
    output logic [ipbs_pkg::DATA_W-1:0] sum
);

    logic [ipbs_pkg::DATA_W-1:0] product;
    logic [ipbs_pkg::DATA_W-1:0] shifted;

    assign product = {32'd0, a} * {32'd0, b};

    always_comb
    begin
        case (shift)
            ipbs_pkg::SH_32: shifted = {product[31:0], 32'd0};
            ipbs_pkg::SH_33: shifted = {product[30:0], 33'd0};
            default:         shifted = product;
        endcase
    end

    assign sum = addend + shifted;

endmodule

// File: rtl/integer_power_by_squaring.sv
// ----------------------------------------------------------------------------
// integer_power_by_squaring
// Signed 64-bit base raised to an 8-bit exponent by square-and-multiply,
// run by a microcoded sequencer over one shared 32 by 32 multiplier.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result appears on power for one cycle with done high, and the
// receiver must take it in that cycle. A unit base, zero base or zero
// exponent jumps from the first microcode step to the finish step; any
// other item runs the microcode loop: per remaining exponent bit one guard
// check, two multiplier passes for the squaring, three more when that bit
// is set, and one shift. Wrapped results are modulo 2^64; a running base
// above 3037000499 before a squaring gives 0.
module integer_power_by_squaring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [63:0]          base_value,
    input  logic [7:0]                  exponent,
    output logic signed [63:0]          power,
    output logic                        done
);

    ipbs_pkg::ucode_t                  uw;
    ipbs_pkg::pc_t                     pc_reg;
    ipbs_pkg::pc_t                     pc_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [ipbs_pkg::DATA_W-1:0]       base_reg;
    logic [ipbs_pkg::DATA_W-1:0]       base_next;
    logic [ipbs_pkg::DATA_W-1:0]       acc_reg;
    logic [ipbs_pkg::DATA_W-1:0]       acc_next;
    logic [ipbs_pkg::DATA_W-1:0]       prod_reg;
    logic [ipbs_pkg::DATA_W-1:0]       prod_next;
    logic [ipbs_pkg::EXP_W-1:0]        rest_reg;
    logic [ipbs_pkg::EXP_W-1:0]        rest_next;
    logic [ipbs_pkg::DATA_W-1:0]       power_reg;
    logic [ipbs_pkg::DATA_W-1:0]       power_next;
    logic [ipbs_pkg::HALF_W-1:0]       mac_a;
    logic [ipbs_pkg::HALF_W-1:0]       mac_b;
    logic [ipbs_pkg::DATA_W-1:0]       mac_addend;
    logic [ipbs_pkg::DATA_W-1:0]       mac_sum;
    logic                              accept;
    logic                              base_one;
    logic                              base_zero;
    logic                              rest_zero;
    logic                              guard_trip;
    logic                              taken;

    assign uw     = ipbs_pkg::ucode_rom(pc_reg);
    assign accept = start && !busy_reg;

    assign base_one   = (base_reg == 64'd1);
    assign base_zero  = (base_reg == 64'd0);
    assign rest_zero  = (rest_reg == 8'd0);
    assign guard_trip = !base_reg[63] && (base_reg[62:0] > ipbs_pkg::GUARD_BOUND[62:0]);

    always_comb
    begin
        case (uw.a_sel)
            ipbs_pkg::A_ACC_LO: mac_a = acc_reg[31:0];
            ipbs_pkg::A_ACC_HI: mac_a = acc_reg[63:32];
            default:            mac_a = base_reg[31:0];
        endcase
    end

    assign mac_b      = (uw.b_sel == ipbs_pkg::B_BASE_HI) ? base_reg[63:32] : base_reg[31:0];
    assign mac_addend = uw.add_prod ? prod_reg : 64'd0;

    ipbs_mac u_mac (
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_addend),
        .shift  (uw.shift),
        .sum    (mac_sum)
    );

    always_comb
    begin
        case (uw.cond)
            ipbs_pkg::COND_ALWAYS:    taken = 1'b1;
            ipbs_pkg::COND_TRIVIAL:   taken = base_one || rest_zero || base_zero;
            ipbs_pkg::COND_STOP:      taken = rest_zero || guard_trip;
            ipbs_pkg::COND_REST_EVEN: taken = !rest_reg[0];
            default:                  taken = 1'b0;
        endcase
    end

    // Sequencer control: step counter, busy flag and result strobe.
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (accept)
        begin
            pc_next   = ipbs_pkg::ST_INIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (uw.op == ipbs_pkg::OP_DONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (taken)
            begin
                pc_next = uw.target;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end
        end
    end

    // Datapath writes selected by the current control word.
    always_comb
    begin
        base_next  = base_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        rest_next  = rest_reg;
        power_next = power_reg;
        if (accept)
        begin
            base_next = base_value;
            rest_next = exponent;
        end
        else if (busy_reg)
        begin
            case (uw.op)
                ipbs_pkg::OP_INIT:
                begin
                    if (taken)
                    begin
                        acc_next = (base_one || rest_zero) ? 64'd1 : 64'd0;
                    end
                    else
                    begin
                        acc_next  = rest_reg[0] ? base_reg : 64'd1;
                        rest_next = rest_reg >> 1;
                    end
                end
                ipbs_pkg::OP_CHECK:
                begin
                    if (!rest_zero && guard_trip)
                    begin
                        acc_next = 64'd0;
                    end
                end
                ipbs_pkg::OP_MAC:
                begin
                    if (!taken)
                    begin
                        case (uw.dst)
                            ipbs_pkg::DST_BASE: base_next = mac_sum;
                            ipbs_pkg::DST_ACC:  acc_next  = mac_sum;
                            default:            prod_next = mac_sum;
                        endcase
                    end
                end
                ipbs_pkg::OP_SHIFT:
                begin
                    rest_next = rest_reg >> 1;
                end
                ipbs_pkg::OP_DONE:
                begin
                    power_next = acc_reg;
                end
                default:
                begin
                    power_next = power_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= ipbs_pkg::ST_INIT;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        rest_reg  <= rest_next;
        power_reg <= power_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign power = power_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("Accepted item did not raise busy.");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("Busy dropped without a result strobe.");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Result strobe without an item in progress.");

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= ipbs_pkg::ST_FINISH))
        else $error("Step counter left the microcode program.");

endmodule
